// ===== hdl/pidpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpd_pkg
// Shared widths, register indexes and saturation helper for the PID block.
// ----------------------------------------------------------------------------
package pidpd_pkg;

  localparam int DataW = 32;
  localparam int ProdW = 48;
  localparam int SumW  = 50;
  localparam int SatW  = 51;
  localparam int LimW  = 31;
  localparam int IdxW  = 3;

  typedef logic [IdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgLoopMode  = 3'd0;
  localparam cfg_idx_t CfgGainP     = 3'd1;
  localparam cfg_idx_t CfgGainI     = 3'd2;
  localparam cfg_idx_t CfgGainD     = 3'd3;
  localparam cfg_idx_t CfgIntLimit  = 3'd4;
  localparam cfg_idx_t CfgDriveMax  = 3'd5;
  localparam cfg_idx_t CfgDriveMin  = 3'd6;

  typedef enum logic {
    FuncStep  = 1'b0,
    FuncClear = 1'b1
  } func_t;

  typedef enum logic {
    ModePositional  = 1'b0,
    ModeIncremental = 1'b1
  } mode_t;

  // Saturates a wide signed value to the signed 32-bit range.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic signed [DataW-1:0] r;
    if ((&v[SatW-1:DataW-1]) || !(|v[SatW-1:DataW-1])) begin
      r = v[DataW-1:0];
    end else if (v[SatW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/pid_position_delta_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_delta_controller_top
// Positional / incremental Q16.16 PID controller with a four-stage pipeline.
// ----------------------------------------------------------------------------
// Order: a request accepted into the pipeline passes error, products, partial
// sum, integral and clamp before its drive shows on out_tvalid.
// Throughput: one request per cycle unless out_tready stalls; the integral and
// last drive close their loop in the final stage: no stall between requests.
// Reset: sync, active low; clears config, valids, history, integral, last drive.
module pid_position_delta_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // setpoint, measured, feedforward_term
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // drive_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DW = pidpd_pkg::DataW;
  localparam int PW = pidpd_pkg::ProdW;
  localparam int SW = pidpd_pkg::SumW;
  localparam int XW = pidpd_pkg::SatW;
  localparam int LW = pidpd_pkg::LimW;

  logic                 mode_r;
  logic signed [DW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [LW-1:0]        int_limit_r;
  logic signed [DW-1:0] drive_max_r, drive_min_r;

  logic signed [DW-1:0] hist0_r, hist1_r;
  logic signed [DW-1:0] integral_r, last_drive_r;

  logic                 v1_r, v2_r, v3_r, out_v_r;
  logic                 rdy1, rdy2, rdy3, rdy4, in_acc;

  logic                 func1_r, func2_r, func3_r;
  logic signed [DW-1:0] e0_1_r, e1_1_r, e2_1_r, ff1_r, ff2_r;
  logic signed [PW-1:0] pp2_r, pi2_r, pd2_r, pi3_r;
  logic signed [SW-1:0] sum3_r;
  logic signed [DW-1:0] out_drive_r;

  logic signed [DW-1:0] e0_in, d1, d2, opnd_p, opnd_d;
  logic signed [PW-1:0] pp, pi, pd;
  logic signed [SW-1:0] pi_sel, sum3_nxt;
  logic signed [XW-1:0] acc, lim, drive;
  logic signed [DW-1:0] integral_nxt, drive_nxt, base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      int_limit_r <= '0;
      drive_max_r <= '0;
      drive_min_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pidpd_pkg::CfgLoopMode: mode_r      <= cfg_data[0];
        pidpd_pkg::CfgGainP:    gain_p_r    <= cfg_data;
        pidpd_pkg::CfgGainI:    gain_i_r    <= cfg_data;
        pidpd_pkg::CfgGainD:    gain_d_r    <= cfg_data;
        pidpd_pkg::CfgIntLimit: int_limit_r <= cfg_data[LW-1:0];
        pidpd_pkg::CfgDriveMax: drive_max_r <= cfg_data;
        pidpd_pkg::CfgDriveMin: drive_min_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rdy4      = !out_v_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && in_tready;

  // Stage 1: error and history.
  assign e0_in = pidpd_pkg::sat32(XW'($signed(in_tdata[31:0])) - XW'($signed(in_tdata[63:32])));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
    end else if (in_acc) begin
      if (in_tuser == pidpd_pkg::FuncClear) begin
        hist0_r <= '0;
        hist1_r <= '0;
      end else begin
        hist0_r <= e0_in;
        hist1_r <= hist0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func1_r <= in_tuser;
      ff1_r   <= $signed(in_tdata[95:64]);
      if (in_tuser == pidpd_pkg::FuncClear) begin
        e0_1_r <= '0;
        e1_1_r <= '0;
        e2_1_r <= '0;
      end else begin
        e0_1_r <= e0_in;
        e1_1_r <= hist0_r;
        e2_1_r <= hist1_r;
      end
    end
  end

  // Stage 2: differences and the three gain products.
  assign d1 = pidpd_pkg::sat32(XW'(e0_1_r) - XW'(e1_1_r));
  assign d2 = pidpd_pkg::sat32(XW'(e0_1_r) - (XW'(e1_1_r) <<< 1) + XW'(e2_1_r));

  assign opnd_p = (mode_r == pidpd_pkg::ModeIncremental) ? d1 : e0_1_r;
  assign opnd_d = (mode_r == pidpd_pkg::ModeIncremental) ? d2 : d1;

  pidpd_qmul u_mul_p (.a(gain_p_r), .b(opnd_p), .q(pp));
  pidpd_qmul u_mul_i (.a(gain_i_r), .b(e0_1_r), .q(pi));
  pidpd_qmul u_mul_d (.a(gain_d_r), .b(opnd_d), .q(pd));

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      func2_r <= func1_r;
      ff2_r   <= ff1_r;
      pp2_r   <= pp;
      pi2_r   <= pi;
      pd2_r   <= pd;
    end
  end

  // Stage 3: partial sum of the terms that do not depend on stored state.
  always_comb begin
    pi_sel = '0;
    if (mode_r == pidpd_pkg::ModeIncremental) begin
      pi_sel = SW'(pi2_r);
    end
    sum3_nxt = SW'(pp2_r) + SW'(pd2_r) + SW'(ff2_r) + pi_sel;
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      func3_r <= func2_r;
      pi3_r   <= pi2_r;
      sum3_r  <= sum3_nxt;
    end
  end

  // Stage 4: integral update, final sum and drive clamp.
  always_comb begin
    acc = XW'(integral_r) + XW'(pi3_r);
    lim = $signed({{(XW-LW){1'b0}}, int_limit_r});
    if (acc > lim) begin
      integral_nxt = DW'(lim);
    end else if (acc < -lim) begin
      integral_nxt = DW'(-lim);
    end else begin
      integral_nxt = acc[DW-1:0];
    end
    base  = (mode_r == pidpd_pkg::ModeIncremental) ? last_drive_r : integral_nxt;
    drive = XW'(sum3_r) + XW'(base);
    if (drive > XW'(drive_max_r)) begin
      drive_nxt = drive_max_r;
    end else if (drive < XW'(drive_min_r)) begin
      drive_nxt = drive_min_r;
    end else begin
      drive_nxt = drive[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      last_drive_r <= '0;
    end else if (v3_r && rdy4) begin
      if (func3_r == pidpd_pkg::FuncClear) begin
        integral_r   <= '0;
        last_drive_r <= '0;
      end else begin
        if (mode_r == pidpd_pkg::ModePositional) begin
          integral_r <= integral_nxt;
        end
        last_drive_r <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      out_drive_r <= (func3_r == pidpd_pkg::FuncClear) ? '0 : drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_acc;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        out_v_r <= v3_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_drive_r;

  a_clear_zeroes_state : assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4 && func3_r == pidpd_pkg::FuncClear)
    |=> (integral_r == '0 && last_drive_r == '0 && out_tdata == '0))
    else $error("clear request left integral or drive nonzero");

  a_last_matches_out : assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4) |=> (last_drive_r == out_drive_r))
    else $error("stored drive differs from delivered drive");

  a_drive_in_bounds : assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4 && func3_r == pidpd_pkg::FuncStep && drive_min_r <= drive_max_r)
    |=> ($signed(out_tdata) <= drive_max_r && $signed(out_tdata) >= drive_min_r))
    else $error("drive outside configured bounds");

  a_clear_history : assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && func1_r == pidpd_pkg::FuncClear)
    |-> (e0_1_r == '0 && e1_1_r == '0 && e2_1_r == '0))
    else $error("clear request carried a nonzero error history");

endmodule

// ===== hdl/pidpd_qmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpd_qmul
// Signed Q16.16 multiplier; the full product is floored by 16 fraction bits.
// ----------------------------------------------------------------------------
module pidpd_qmul (
  input  logic signed [pidpd_pkg::DataW-1:0] a,
  input  logic signed [pidpd_pkg::DataW-1:0] b,
  output logic signed [pidpd_pkg::ProdW-1:0] q
);

  logic signed [2*pidpd_pkg::DataW-1:0] prod;

  assign prod = a * b;
  assign q    = prod[2*pidpd_pkg::DataW-1:2*pidpd_pkg::DataW-pidpd_pkg::ProdW];

endmodule
